>>> rtl/core/ssin_pkg.sv
// ----------------------------------------------------------------------------
// ssin_pkg
// Shared constants and types for the item-name substring search block.
// ----------------------------------------------------------------------------
package ssin_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int POSITION_BITS = 16;
    localparam int OFFSET_BITS   = 16;
    localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
    // The internal position counter runs a little past the saturation point so
    // that the start of a match can be recovered by subtracting its length.
    localparam int TPOS_BITS     = POSITION_BITS + 1;

    localparam logic [TPOS_BITS-1:0] POS_LIMIT =
        TPOS_BITS'((64'd1 << POSITION_BITS) - 64'd1);
    localparam logic [TPOS_BITS-1:0] POS_CAP =
        TPOS_BITS'((64'd1 << POSITION_BITS) - 64'd1 + 64'(PATTERN_MAX));

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_ITEM_NAME_MODE = 3'd3,
        CFG_LINE_ONLY_MODE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] pattern;
        logic [LEN_BITS-1:0]         length;   // effective length
        logic                        item_name_mode;
        logic                        line_only_mode;
    } cfg_t;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
    } result_t;

endpackage

>>> rtl/core/ssin_cfg.sv
// ----------------------------------------------------------------------------
// ssin_cfg
// Configuration registers and the effective pattern length.
// ----------------------------------------------------------------------------
module ssin_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               write_en,
    input  logic [2:0]         write_index,
    input  logic [63:0]        write_data,
    output ssin_pkg::cfg_t     cfg
);

    logic [63:0]                   pattern_low_reg;
    logic [63:0]                   pattern_high_reg;
    logic [ssin_pkg::LEN_BITS-1:0] pattern_length_reg;
    logic                          item_name_mode_reg;
    logic                          line_only_mode_reg;

    logic [ssin_pkg::PATTERN_MAX-1:0][7:0] pattern;
    logic [ssin_pkg::LEN_BITS-1:0]         clamped_len;
    logic [ssin_pkg::LEN_BITS-1:0]         eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            item_name_mode_reg <= 1'b0;
            line_only_mode_reg <= 1'b0;
        end
        else if (write_en)
        begin
            case (ssin_pkg::cfg_index_t'(write_index))
                ssin_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= write_data;
                ssin_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= write_data;
                ssin_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= write_data[ssin_pkg::LEN_BITS-1:0];
                ssin_pkg::CFG_ITEM_NAME_MODE: item_name_mode_reg <= write_data[0];
                ssin_pkg::CFG_LINE_ONLY_MODE: line_only_mode_reg <= write_data[0];
                default: ;
            endcase
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    // The pattern ends at the first zero byte within the requested length.
    always_comb
    begin
        if (pattern_length_reg > ssin_pkg::LEN_BITS'(ssin_pkg::PATTERN_MAX))
            clamped_len = ssin_pkg::LEN_BITS'(ssin_pkg::PATTERN_MAX);
        else
            clamped_len = pattern_length_reg;
        eff_len = clamped_len;
        for (int i = ssin_pkg::PATTERN_MAX - 1; i >= 0; i--)
        begin
            if ((ssin_pkg::LEN_BITS'(i) < clamped_len) && (pattern[i] == ssin_pkg::CHAR_NUL))
                eff_len = ssin_pkg::LEN_BITS'(i);
        end
    end

    assign cfg.pattern        = pattern;
    assign cfg.length         = eff_len;
    assign cfg.item_name_mode = item_name_mode_reg;
    assign cfg.line_only_mode = line_only_mode_reg;

endmodule

>>> rtl/core/ssin_scan.sv
// ----------------------------------------------------------------------------
// ssin_scan
// Per-character scan: quote and separator tracking, partial-match vector and
// first-match capture.
// ----------------------------------------------------------------------------
module ssin_scan
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         text_char,
    input  logic               end_of_text,
    input  ssin_pkg::cfg_t     cfg,
    output logic               result_valid,
    output ssin_pkg::result_t  result
);

    localparam int PM = ssin_pkg::PATTERN_MAX;
    localparam int TB = ssin_pkg::TPOS_BITS;

    logic                                quoted_reg;
    logic                                only_space_reg;
    logic                                line_stopped_reg;
    logic [TB-1:0]                       pos_reg;
    logic                                found_reg;
    logic [ssin_pkg::POSITION_BITS-1:0]  first_off_reg;
    // Bit k: the last k+1 characters match the first k+1 pattern bytes and
    // a start was allowed at the first of them.
    logic [PM-1:0]                       partial_reg;

    logic                                quoted_now;
    logic                                allowed;
    logic                                is_sep;
    logic                                is_ws;
    logic                                is_alnum;
    logic                                is_break;
    logic [PM-1:0]                       eq;
    logic [PM-1:0]                       partial_now;
    logic [PM-1:0]                       len_sel;
    logic                                len_zero;
    logic                                hit_follow;
    logic                                hit_end;
    logic [TB-1:0]                       start_pos;
    logic [ssin_pkg::POSITION_BITS-1:0]  start_sat;
    logic                                found_now;
    logic [ssin_pkg::POSITION_BITS-1:0]  offset_now;

    always_comb
    begin
        quoted_now = quoted_reg ^ (text_char == ssin_pkg::CHAR_QUOTE);
        allowed    = !(cfg.line_only_mode && line_stopped_reg)
                     && !(cfg.item_name_mode && (quoted_now || !only_space_reg));
        is_sep   = (text_char == ssin_pkg::CHAR_NL) || (text_char == ssin_pkg::CHAR_SEMI)
                   || (text_char == ssin_pkg::CHAR_TAB) || (text_char == ssin_pkg::CHAR_COMMA);
        is_ws    = (text_char == ssin_pkg::CHAR_SPACE) || (text_char == ssin_pkg::CHAR_TAB)
                   || (text_char == ssin_pkg::CHAR_NL) || (text_char == ssin_pkg::CHAR_VT)
                   || (text_char == ssin_pkg::CHAR_FF) || (text_char == ssin_pkg::CHAR_CR);
        is_alnum = ((text_char >= 8'h30) && (text_char <= 8'h39))
                   || ((text_char >= 8'h41) && (text_char <= 8'h5A))
                   || ((text_char >= 8'h61) && (text_char <= 8'h7A));
        is_break = ((text_char == ssin_pkg::CHAR_NL) || (text_char == ssin_pkg::CHAR_SEMI))
                   && !quoted_now;

        for (int k = 0; k < PM; k++)
        begin
            eq[k]      = (text_char == cfg.pattern[k]);
            len_sel[k] = (cfg.length == ssin_pkg::LEN_BITS'(k + 1));
        end
        len_zero    = (cfg.length == '0);
        partial_now = {partial_reg[PM-2:0], allowed} & eq;

        // A match that ended on the previous character has this one as its
        // follower; at the end of the string a match may also end here.
        hit_follow = !found_reg && (|(partial_reg & len_sel))
                     && !(cfg.item_name_mode && is_alnum);
        hit_end    = end_of_text && !found_reg && !hit_follow
                     && (|(partial_now & len_sel));

        start_pos = pos_reg - TB'(cfg.length) + {{(TB-1){1'b0}}, hit_end};
        if (start_pos > ssin_pkg::POS_LIMIT)
            start_sat = ssin_pkg::POS_LIMIT[ssin_pkg::POSITION_BITS-1:0];
        else
            start_sat = start_pos[ssin_pkg::POSITION_BITS-1:0];

        found_now = found_reg || hit_follow || hit_end;
        if (found_reg)
            offset_now = first_off_reg;
        else if (hit_follow || hit_end)
            offset_now = start_sat;
        else
            offset_now = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg       <= 1'b0;
            only_space_reg   <= 1'b1;
            line_stopped_reg <= 1'b0;
            pos_reg          <= '0;
            found_reg        <= 1'b0;
            first_off_reg    <= '0;
            partial_reg      <= '0;
        end
        else if (step)
        begin
            if (end_of_text)
            begin
                quoted_reg       <= 1'b0;
                only_space_reg   <= 1'b1;
                line_stopped_reg <= 1'b0;
                pos_reg          <= '0;
                found_reg        <= 1'b0;
                first_off_reg    <= '0;
                partial_reg      <= '0;
            end
            else
            begin
                quoted_reg <= quoted_now;
                if (is_sep)
                    only_space_reg <= 1'b1;
                else if (!is_ws)
                    only_space_reg <= 1'b0;
                if (is_break)
                    line_stopped_reg <= 1'b1;
                if (pos_reg < ssin_pkg::POS_CAP)
                    pos_reg <= pos_reg + TB'(1);
                found_reg     <= found_now;
                first_off_reg <= offset_now;
                partial_reg   <= partial_now;
            end
        end
    end

    assign result_valid  = step && end_of_text;
    assign result.found  = len_zero || found_now;
    assign result.offset = len_zero ? '0 : ssin_pkg::OFFSET_BITS'(offset_now);

endmodule

>>> rtl/core/substring_search_item_name_core.sv
// ----------------------------------------------------------------------------
// substring_search_item_name_core
// Streaming first-occurrence search of a configured pattern in a string.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle unless stalled, with tlast
// on the final character of each string, and returns one word per string:
// tuser is the match flag and tdata the offset of the first accepted match
// start. A string's result is registered in the output register. The rate
// is set by the per-character update of the partial-match vector, one
// comparator per pattern byte, which is combinational. The output register
// lets the next string stream in while a result waits; only a second final
// character stalls behind it.
// ----------------------------------------------------------------------------
module substring_search_item_name_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] text_char
    input  logic        s_tlast,     // end_of_text

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] match_offset
    output logic        m_tuser,     // [0] match_found

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    ssin_pkg::cfg_t    cfg;
    ssin_pkg::result_t scan_result;
    logic              scan_valid;

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    ssin_pkg::result_t out_reg;

    logic              advance;
    logic              in_take;

    assign cfg_ready = 1'b1;

    ssin_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (cfg_valid && cfg_ready),
        .write_index (cfg_index),
        .write_data  (cfg_data),
        .cfg         (cfg)
    );

    // Only a final character needs room in the output register.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    ssin_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .text_char    (in_char_reg),
        .end_of_text  (in_last_reg),
        .cfg          (cfg),
        .result_valid (scan_valid),
        .result       (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (scan_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (scan_valid)
            out_reg <= scan_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.offset;
    assign m_tuser  = out_reg.found;

endmodule
